/* rtl/core/utf8d_pkg.sv */
// shared types and constants for the utf-8 stream decoder
`default_nettype none
package utf8d_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00fffd;
    localparam logic [CP_W-1:0] MAX_SCALAR  = 21'h10ffff;
    localparam logic [CP_W-1:0] MIN_CP4     = 21'h010000;
    localparam logic [CP_W-1:0] MIN_CP3     = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP2     = 21'h000080;

    // lead byte classes, compared under mask
    localparam logic [7:0] MASK_LEAD2 = 8'he0;
    localparam logic [7:0] CODE_LEAD2 = 8'hc0;
    localparam logic [7:0] MASK_LEAD3 = 8'hf0;
    localparam logic [7:0] CODE_LEAD3 = 8'he0;
    localparam logic [7:0] MASK_LEAD4 = 8'hf8;
    localparam logic [7:0] CODE_LEAD4 = 8'hf0;
    localparam logic [7:0] MASK_CONT  = 8'hc0;
    localparam logic [7:0] CODE_CONT  = 8'h80;

    // results caused by one input byte: replacements first, then at most one final code point
    typedef struct packed {
        logic [1:0]      rep_cnt;
        logic            has_final;
        logic [CP_W-1:0] final_cp;
        logic            final_bad;
    } t_bundle;

endpackage
`default_nettype wire

/* rtl/core/utf8d_decode.sv */
// byte decoder: sequence state and per-byte result bundle
`default_nettype none
module utf8d_decode (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_take,
    input  wire logic [7:0]         i_byte,
    output utf8d_pkg::t_bundle      o_bundle
);
    import utf8d_pkg::*;

    logic [1:0]      r_remain, n_remain;
    logic [1:0]      r_held, n_held;
    logic [CP_W-1:0] r_acc, n_acc;

    logic            is_cont;
    logic [CP_W-1:0] acc_next;
    logic            good;

    assign is_cont  = (i_byte & MASK_CONT) == CODE_CONT;
    assign acc_next = {r_acc[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        unique case (r_held)
            2'd1:    good = acc_next >= MIN_CP2;
            2'd2:    good = acc_next >= MIN_CP3;
            default: good = (acc_next >= MIN_CP4) && (acc_next <= MAX_SCALAR);
        endcase
    end

    always_comb begin
        o_bundle  = '0;
        n_remain  = r_remain;
        n_held    = r_held;
        n_acc     = r_acc;
        if (r_remain != 2'd0 && is_cont) begin
            if (r_remain == 2'd1) begin
                o_bundle.has_final = 1'b1;
                o_bundle.final_cp  = good ? acc_next : REPLACEMENT;
                o_bundle.final_bad = !good;
                n_remain           = 2'd0;
                n_held             = 2'd0;
                n_acc              = '0;
            end else begin
                n_acc    = acc_next;
                n_held   = r_held + 2'd1;
                n_remain = r_remain - 2'd1;
            end
        end else begin
            // broken sequence: one replacement per held byte, then decode afresh
            if (r_remain != 2'd0) begin
                o_bundle.rep_cnt = r_held;
            end
            n_remain = 2'd0;
            n_held   = 2'd0;
            n_acc    = '0;
            priority if (i_byte == 8'd0) begin
                // terminator, no code point of its own
            end else if (!i_byte[7]) begin
                o_bundle.has_final = 1'b1;
                o_bundle.final_cp  = {{(CP_W-8){1'b0}}, i_byte};
            end else if ((i_byte & MASK_LEAD2) == CODE_LEAD2) begin
                n_acc    = {{(CP_W-5){1'b0}}, i_byte[4:0]};
                n_remain = 2'd1;
                n_held   = 2'd1;
            end else if ((i_byte & MASK_LEAD3) == CODE_LEAD3) begin
                n_acc    = {{(CP_W-4){1'b0}}, i_byte[3:0]};
                n_remain = 2'd2;
                n_held   = 2'd1;
            end else if ((i_byte & MASK_LEAD4) == CODE_LEAD4) begin
                n_acc    = {{(CP_W-3){1'b0}}, i_byte[2:0]};
                n_remain = 2'd3;
                n_held   = 2'd1;
            end else begin
                o_bundle.has_final = 1'b1;
                o_bundle.final_cp  = REPLACEMENT;
                o_bundle.final_bad = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain <= 2'd0;
            r_held   <= 2'd0;
            r_acc    <= '0;
        end else if (i_take) begin
            r_remain <= n_remain;
            r_held   <= n_held;
            r_acc    <= n_acc;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/utf8d_burst.sv */
// result register that plays one bundle out as a burst of beats
`default_nettype none
module utf8d_burst (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire utf8d_pkg::t_bundle          i_bundle,
    output logic                             o_free,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [utf8d_pkg::CP_W-1:0]       o_code_point,
    output logic                             o_malformed,
    output logic                             o_last_in_run
);
    import utf8d_pkg::*;

    t_bundle r_bundle;
    logic    r_valid;
    logic    take;
    logic    is_empty;

    assign is_empty      = (i_bundle.rep_cnt == 2'd0) && !i_bundle.has_final;
    assign take          = r_valid && i_ready;
    assign o_valid       = r_valid;
    assign o_last_in_run = (r_bundle.rep_cnt == 2'd0)
                        || ((r_bundle.rep_cnt == 2'd1) && !r_bundle.has_final);
    assign o_code_point  = (r_bundle.rep_cnt != 2'd0) ? REPLACEMENT : r_bundle.final_cp;
    assign o_malformed   = (r_bundle.rep_cnt != 2'd0) || r_bundle.final_bad;
    assign o_free        = !r_valid || (take && o_last_in_run);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (take && o_last_in_run) begin
                r_valid <= 1'b0;
            end
            if (i_load && !is_empty) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && !is_empty) begin
            r_bundle <= i_bundle;
        end else if (take && r_bundle.rep_cnt != 2'd0) begin
            r_bundle.rep_cnt <= r_bundle.rep_cnt - 2'd1;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/utf8_stream_decoder.sv */
// top level of the utf-8 stream decoder with replacement
// the first result of a byte appears in the cycle after the byte's beat
// throughput: one byte per cycle with i_ready high and at most one result per byte
// a byte with n results (n up to 4) holds the result register until all are taken
// reset (i_rst_n low at a clock edge) drops any open sequence and any pending result
`default_nettype none
module utf8_stream_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    // code point output channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [20:0]      o_code_point,
    output logic             o_malformed,
    output logic             o_last_in_run
);
    import utf8d_pkg::*;

    t_bundle bundle;
    logic    free;
    logic    take_in;

    // a new byte is taken whenever the result register is empty or drains its last beat
    assign o_ready = free;
    assign take_in = i_valid && free;

    // sequence state and classification of the incoming byte
    utf8d_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take_in),
        .i_byte   (i_data_byte),
        .o_bundle (bundle)
    );

    // bytes that give no result (leads, mid-sequence continuations, lone terminator)
    // never occupy the result register
    utf8d_burst u_burst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (take_in),
        .i_bundle      (bundle),
        .o_free        (free),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_point  (o_code_point),
        .o_malformed   (o_malformed),
        .o_last_in_run (o_last_in_run)
    );

endmodule
`default_nettype wire
